// ===== hw/rtl/snts_pkg.sv =====
// ----------------------------------------------------------------------------
// snts_pkg
// types and constants shared by the task scheduler
// ----------------------------------------------------------------------------
package snts_pkg;

	localparam logic [1:0] ST_BLOCKED = 2'd0;
	localparam logic [1:0] ST_READY   = 2'd1;
	localparam logic [1:0] ST_RUNNING = 2'd2;
	localparam logic [1:0] ST_TERM    = 2'd3;

	localparam logic [2:0] EV_START = 3'd0;
	localparam logic [2:0] EV_BLOCK = 3'd1;
	localparam logic [2:0] EV_TERM  = 3'd2;
	localparam logic [2:0] EV_IDLEB = 3'd3;
	localparam logic [2:0] EV_IDLEE = 3'd4;
	localparam logic [2:0] EV_DONE  = 3'd5;

	localparam logic REG_BLOCK_DURATION = 1'b0;
	localparam logic REG_TASK_COUNT     = 1'b1;

	localparam int SUM_BITS = 36;

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  slot;
		logic [31:0] etime;
		logic [35:0] sum;
		logic        last;
	} event_t;

endpackage

// ===== hw/rtl/shortest_next_task_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// shortest_next_task_scheduler_unit
// non-preemptive shortest-process-next task scheduler
// ----------------------------------------------------------------------------
// Per-slot task state lives in one synchronous memory whose read data is
// registered. After reset a clearing pass writes every slot as blocked with
// zero times; no beat is taken during it. A tick beat for N active slots is
// taken, then walked slot by slot with a read/modify/write, then a read pass
// selects the shortest ready burst while counting finished slots and summing
// finish times; a start adds a read and a write. A tick after done is taken
// and ignored. Events leave through a four-entry queue; a tick is taken only
// once the queue is empty. Up to two event beats per tick, tlast on the last
// one. A register write offered in the same cycle as a load or tick beat goes
// first.
// ----------------------------------------------------------------------------
module shortest_next_task_scheduler_unit
	import snts_pkg::*;
#(
	parameter int MAX_TASKS = 16,
	parameter int TIME_BITS = 32
)(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // task_slot, arrival tick, run ticks, burst_length
	input  logic        s_axis_tuser,  // mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,  // event_kind, event_slot, event_time, turnaround_total
	output logic        m_axis_tlast,  // last
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam logic [TIME_BITS-1:0] TMAX = '1;
	localparam logic [TIME_BITS-1:0] TONE = {{(TIME_BITS-1){1'b0}}, 1'b1};

	typedef struct packed {
		logic [1:0]           st;
		logic [16:0]          cd;
		logic [15:0]          rem;
		logic [15:0]          prog;
		logic [15:0]          lim;
		logic [TIME_BITS-1:0] fin;
	} entry_t;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_LOAD  = 4'd1;
	localparam logic [3:0] S_WRD   = 4'd2;
	localparam logic [3:0] S_WWB   = 4'd3;
	localparam logic [3:0] S_SRD   = 4'd4;
	localparam logic [3:0] S_SCHK  = 4'd5;
	localparam logic [3:0] S_STRD  = 4'd6;
	localparam logic [3:0] S_STWB  = 4'd7;
	localparam logic [3:0] S_FIN   = 4'd8;
	localparam logic [3:0] S_CLR   = 4'd9;

	entry_t mem [MAX_TASKS];
	entry_t rd_q;
	logic   we;
	logic [SW-1:0] waddr, raddr;
	entry_t wdata;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	logic [3:0] state_q;
	logic [15:0] bdur_q;
	logic [4:0]  tcnt_q;
	logic        run_v_q, idle_q, done_q;
	logic [SW-1:0] run_s_q;
	logic [TIME_BITS-1:0] sys_q, intv_q;
	logic [SW:0] i_q;
	logic [51:0] ld_q;
	logic        found_q;
	logic [SW-1:0] best_q;
	logic [15:0] best_lim_q;
	logic [CW-1:0] fcnt_q;
	logic [SUM_BITS-1:0] sum_q;
	logic [MAX_TASKS-1:0] cand_q;

	logic [CW-1:0] n;
	always_comb begin
		if ({27'd0, tcnt_q} > MAX_TASKS) n = CW'(MAX_TASKS);
		else n = CW'(tcnt_q);
	end

	logic ld_ok;
	assign ld_ok = (32'(ld_q[3:0]) < MAX_TASKS);

	event_t ev;
	logic   push, q_empty;
	event_t qout;
	assign m_axis_tdata = {5'b0, qout.sum, qout.etime, qout.slot, qout.kind};
	assign m_axis_tlast = qout.last;

	assign s_axis_tready = (state_q == S_IDLE) && q_empty && !cfg_valid;
	assign cfg_ready = (state_q == S_IDLE);

	function automatic logic [31:0] t32(logic [TIME_BITS-1:0] v);
		logic [47:0] w;
		w = 48'(v);
		return w[31:0];
	endfunction

	function automatic logic [TIME_BITS-1:0] sinc(logic [TIME_BITS-1:0] v);
		return (v == TMAX) ? v : v + 1'b1;
	endfunction

	logic [SW-1:0] ci;
	assign ci = i_q[SW-1:0];
	logic is_run;
	assign is_run = run_v_q && run_s_q == ci;
	logic [SUM_BITS:0] sum_add;
	assign sum_add = {1'b0, sum_q} + (SUM_BITS+1)'(rd_q.fin);

	// walk decisions
	entry_t wn;
	logic   wcand, wblk, wterm;
	always_comb begin
		wn = rd_q;
		wcand = 1'b0;
		wblk = 1'b0;
		wterm = 1'b0;
		case (rd_q.st)
			ST_BLOCKED: begin
				if (rd_q.cd <= 17'd1) begin
					wn.st = ST_READY;
					wn.cd = {1'b0, bdur_q};
					wcand = 1'b1;
				end else wn.cd = rd_q.cd - 17'd1;
			end
			ST_READY: wcand = 1'b1;
			ST_RUNNING: begin
				if (!is_run) begin
					wn.st = ST_READY;
					wcand = 1'b1;
				end else if (rd_q.rem != 16'd0) begin
					if (rd_q.prog < rd_q.lim) begin
						wn.prog = rd_q.prog + 16'd1;
						wn.rem = rd_q.rem - 16'd1;
					end else begin
						wn.prog = '0;
						wn.st = ST_BLOCKED;
						wblk = 1'b1;
					end
				end else begin
					wn.st = ST_TERM;
					wn.fin = sys_q;
					wterm = 1'b1;
				end
			end
			default: ;
		endcase
	end

	logic fin_all;
	assign fin_all = (fcnt_q == n);

	always_comb begin
		we = 1'b0;
		waddr = ci;
		wdata = wn;
		raddr = ci;
		push = 1'b0;
		ev = '0;
		unique case (state_q)
			S_IDLE: raddr = '0;
			S_CLR: begin
				we = 1'b1;
				wdata = '0;
			end
			S_LOAD: begin
				we = ld_ok;
				waddr = SW'(ld_q[3:0]);
				wdata.st = ST_BLOCKED;
				wdata.cd = {1'b0, ld_q[19:4]};
				wdata.rem = ld_q[35:20];
				wdata.prog = '0;
				wdata.lim = ld_q[51:36];
				wdata.fin = '0;
			end
			S_WRD: ;
			S_WWB: begin
				we = 1'b1;
				if (wblk || wterm) begin
					push = 1'b1;
					ev.kind = wblk ? EV_BLOCK : EV_TERM;
					ev.slot = 4'(ci);
					ev.etime = t32(intv_q);
				end
			end
			S_SRD: ;
			S_SCHK: ;
			S_STRD: raddr = best_q;
			S_STWB: begin
				we = 1'b1;
				waddr = best_q;
				wdata = rd_q;
				wdata.st = ST_RUNNING;
				if (rd_q.rem != 16'd0) wdata.rem = rd_q.rem - 16'd1;
				if (rd_q.prog != 16'hFFFF) wdata.prog = rd_q.prog + 16'd1;
				push = 1'b1;
				ev.kind = EV_START;
				ev.slot = 4'(best_q);
				ev.etime = t32(sys_q);
			end
			S_FIN: ;
			default: ;
		endcase
	end

	// extra event pushes from the sequencer use a combinational path
	logic   push2;
	event_t ev2;
	// merged push into queue is limited to one per cycle; sequencer below
	// never pushes from S_STWB and S_SCHK/S_FIN in the same cycle
	logic   sp;
	event_t se;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			bdur_q <= 16'd1;
			tcnt_q <= 5'd1;
			run_v_q <= 1'b0;
			run_s_q <= '0;
			idle_q <= 1'b0;
			done_q <= 1'b0;
			sys_q <= '0;
			intv_q <= '0;
			i_q <= '0;
			found_q <= 1'b0;
			best_q <= '0;
			best_lim_q <= '0;
			fcnt_q <= '0;
			sum_q <= '0;
			cand_q <= '0;
			ld_q <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					if (i_q == (SW+1)'(MAX_TASKS - 1)) begin
						i_q <= '0;
						state_q <= S_IDLE;
					end else i_q <= i_q + 1'b1;
				end
				S_IDLE: begin
					if (cfg_valid && cfg_ready) begin
						if (cfg_index == REG_BLOCK_DURATION) bdur_q <= cfg_data;
						else tcnt_q <= cfg_data[4:0];
					end else if (s_axis_tvalid && s_axis_tready) begin
						if (!s_axis_tuser) begin
							ld_q <= s_axis_tdata[51:0];
							state_q <= S_LOAD;
						end else if (!done_q) begin
							if (run_v_q && ({1'b0, run_s_q} >= (SW+1)'(n)))
								run_v_q <= 1'b0;
							i_q <= '0;
							cand_q <= '0;
							found_q <= 1'b0;
							fcnt_q <= '0;
							sum_q <= '0;
							state_q <= (n == '0) ? S_SRD : S_WRD;
						end
					end
				end
				S_LOAD: begin
					if (ld_ok) begin
						if (run_v_q && run_s_q == SW'(ld_q[3:0])) run_v_q <= 1'b0;
						done_q <= 1'b0;
					end
					state_q <= S_IDLE;
				end
				S_WRD: state_q <= S_WWB;
				S_WWB: begin
					cand_q[ci] <= wcand;
					if (wblk || wterm) begin
						run_v_q <= 1'b0;
						intv_q <= '0;
					end
					if ((i_q + 1'b1) == (SW+1)'(n)) begin
						i_q <= '0;
						found_q <= 1'b0;
						fcnt_q <= '0;
						sum_q <= '0;
						state_q <= S_SRD;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= S_WRD;
					end
				end
				S_SRD: begin
					if (i_q == (SW+1)'(n)) state_q <= S_SCHK;
					else state_q <= S_FIN;
				end
				S_FIN: begin
					if (rd_q.st == ST_TERM) fcnt_q <= fcnt_q + 1'b1;
					sum_q <= sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
					if (cand_q[ci] && (!found_q || rd_q.lim < best_lim_q)) begin
						found_q <= 1'b1;
						best_q <= ci;
						best_lim_q <= rd_q.lim;
					end
					i_q <= i_q + 1'b1;
					state_q <= S_SRD;
				end
				S_SCHK: begin
					if (!run_v_q && found_q) begin
						if (idle_q) idle_q <= 1'b0;
						state_q <= S_STRD;
					end else begin
						if (!run_v_q && !fin_all && !idle_q) idle_q <= 1'b1;
						if (fin_all) done_q <= 1'b1;
						else begin
							intv_q <= sinc(intv_q);
							sys_q <= sinc(sys_q);
						end
						state_q <= S_IDLE;
					end
				end
				S_STRD: state_q <= S_STWB;
				S_STWB: begin
					run_v_q <= 1'b1;
					run_s_q <= best_q;
					intv_q <= TONE;
					sys_q <= sinc(sys_q);
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// side events: idle end before start, idle begin / done at end of tick
	always_comb begin
		sp = 1'b0;
		se = '0;
		if (state_q == S_SCHK) begin
			if (!run_v_q && found_q) begin
				if (idle_q) begin
					sp = 1'b1;
					se.kind = EV_IDLEE;
					se.etime = t32(intv_q);
				end
			end else if (fin_all) begin
				sp = 1'b1;
				se.kind = EV_DONE;
				se.etime = t32(sys_q);
				se.sum = sum_q;
			end else if (!run_v_q && !idle_q) begin
				sp = 1'b1;
				se.kind = EV_IDLEB;
				se.etime = t32(sys_q);
			end
		end
		push2 = push || sp;
		ev2 = push ? ev : se;
		ev2.last = (state_q == S_STWB) ||
			(state_q == S_SCHK && !(!run_v_q && found_q));
	end

	// final queue feed
	event_t qin;
	assign qin = ev2;
	logic qpush;
	assign qpush = push2;

	snts_evq u_evq (
		.clk(clk), .arst_n(arst_n), .push(qpush), .din(qin), .empty(q_empty),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .dout(qout)
	);
endmodule

// ===== hw/rtl/snts_evq.sv =====
// ----------------------------------------------------------------------------
// snts_evq
// small event queue between the scheduler core and the output stream
// ----------------------------------------------------------------------------
module snts_evq
	import snts_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  event_t din,
	output logic   empty,
	output logic   m_axis_tvalid,
	input  logic   m_axis_tready,
	output event_t dout
);
	event_t mem_q [4];
	logic [2:0] wp_q, rp_q;

	assign empty = (wp_q == rp_q);
	assign m_axis_tvalid = !empty;
	assign dout = mem_q[rp_q[1:0]];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q[1:0]] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 3'd1;
			if (m_axis_tvalid && m_axis_tready) rp_q <= rp_q + 3'd1;
		end
	end
endmodule

// ===== tb/shortest_next_task_scheduler_unit_checker.sv =====
// ----------------------------------------------------------------------------
// shortest_next_task_scheduler_unit_checker
// watches the load/tick, event and register channels of the scheduler, keeps
// its own copy of the task slots, predicts the events of every tick beat and
// compares each event beat field by field with the oldest prediction
// ----------------------------------------------------------------------------
module shortest_next_task_scheduler_unit_checker
	import snts_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // task_slot, arrival tick, run ticks, burst_length
	input  logic        s_axis_tuser,  // mode
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [79:0] m_axis_tdata,  // event_kind, event_slot, event_time, turnaround_total
	input  logic        m_axis_tlast,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 16;

	logic [1:0]  slot_st   [SLOTS];
	logic [16:0] countdown [SLOTS];
	logic [15:0] work_left [SLOTS];
	logic [15:0] progress  [SLOTS];
	logic [15:0] burst_lim [SLOTS];
	logic [31:0] finished_at [SLOTS];
	logic        run_v;
	logic [3:0]  run_s;
	logic [31:0] sys_time;
	logic [31:0] span;
	logic        idle_on;
	logic        sched_done;
	logic [15:0] block_len;
	logic [4:0]  active_cnt;

	event_t event_q[$];
	event_t tick_events[$];

	assign pending = event_q.size();

	function automatic logic [31:0] sat_inc(logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	task automatic note_event(logic [2:0] kind, logic [3:0] slot, logic [31:0] t,
			logic [35:0] sum);
		event_t e;
		e.kind = kind;
		e.slot = slot;
		e.etime = t;
		e.sum = sum;
		e.last = 1'b0;
		tick_events.insert(tick_events.size(), e);
	endtask

	task automatic load_slot(logic [55:0] d);
		logic [3:0] s;
		s = d[3:0];
		slot_st[s] = ST_BLOCKED;
		countdown[s] = {1'b0, d[19:4]};
		work_left[s] = d[35:20];
		progress[s] = '0;
		burst_lim[s] = d[51:36];
		finished_at[s] = '0;
		if (run_v && run_s == s)
			run_v = 1'b0;
		sched_done = 1'b0;
	endtask

	task automatic schedule_tick();
		int n;
		int best;
		int term_cnt;
		logic found;
		logic cand [SLOTS];
		logic [36:0] total;
		event_t e;
		n = (active_cnt > SLOTS) ? SLOTS : active_cnt;
		tick_events.delete();
		if (sched_done)
			return;
		if (run_v && run_s >= n)
			run_v = 1'b0;
		for (int i = 0; i < n; i++) begin
			cand[i] = 1'b0;
			case (slot_st[i])
				ST_BLOCKED: begin
					if (countdown[i] <= 1) begin
						slot_st[i] = ST_READY;
						countdown[i] = {1'b0, block_len};
						cand[i] = 1'b1;
					end else begin
						countdown[i] = countdown[i] - 1;
					end
				end
				ST_READY: cand[i] = 1'b1;
				ST_RUNNING: begin
					if (!(run_v && run_s == i)) begin
						slot_st[i] = ST_READY;
						cand[i] = 1'b1;
					end else if (work_left[i] > 0) begin
						if (progress[i] < burst_lim[i]) begin
							progress[i]++;
							work_left[i]--;
						end else begin
							progress[i] = '0;
							note_event(EV_BLOCK, 4'(i), span, '0);
							slot_st[i] = ST_BLOCKED;
							run_v = 1'b0;
							span = '0;
						end
					end else begin
						note_event(EV_TERM, 4'(i), span, '0);
						slot_st[i] = ST_TERM;
						finished_at[i] = sys_time;
						run_v = 1'b0;
						span = '0;
					end
				end
				default: ;
			endcase
		end
		if (!run_v) begin
			found = 1'b0;
			best = 0;
			for (int i = 0; i < n; i++)
				if (cand[i] && (!found || burst_lim[i] < burst_lim[best])) begin
					best = i;
					found = 1'b1;
				end
			if (found) begin
				if (idle_on) begin
					note_event(EV_IDLEE, '0, span, '0);
					idle_on = 1'b0;
				end
				slot_st[best] = ST_RUNNING;
				if (work_left[best] > 0)
					work_left[best]--;
				if (progress[best] < 16'hFFFF)
					progress[best]++;
				span = '0;
				run_v = 1'b1;
				run_s = 4'(best);
				note_event(EV_START, 4'(best), sys_time, '0);
			end
		end
		term_cnt = 0;
		for (int i = 0; i < n; i++)
			if (slot_st[i] == ST_TERM)
				term_cnt++;
		if (!run_v && term_cnt != n && !idle_on) begin
			idle_on = 1'b1;
			note_event(EV_IDLEB, '0, sys_time, '0);
		end
		if (term_cnt == n) begin
			total = '0;
			for (int i = 0; i < n; i++) begin
				total = total + finished_at[i];
				if (total > 37'h0F_FFFF_FFFF)
					total = 37'h0F_FFFF_FFFF;
			end
			note_event(EV_DONE, '0, sys_time, total[35:0]);
			sched_done = 1'b1;
		end else begin
			span = sat_inc(span);
			sys_time = sat_inc(sys_time);
		end
		for (int k = 0; k < tick_events.size(); k++) begin
			e = tick_events[k];
			e.last = (k == tick_events.size() - 1);
			event_q.insert(event_q.size(), e);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		event_t got;
		event_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_st[i] = ST_BLOCKED;
				countdown[i] = '0;
				work_left[i] = '0;
				progress[i] = '0;
				burst_lim[i] = '0;
				finished_at[i] = '0;
			end
			run_v = 1'b0;
			run_s = '0;
			sys_time = '0;
			span = '0;
			idle_on = 1'b0;
			sched_done = 1'b0;
			block_len = 16'd1;
			active_cnt = 5'd1;
			event_q.delete();
			fail_count = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.kind = m_axis_tdata[2:0];
				got.slot = m_axis_tdata[6:3];
				got.etime = m_axis_tdata[38:7];
				got.sum = m_axis_tdata[74:39];
				got.last = m_axis_tlast;
				if (event_q.size() == 0) begin
					$display("%0t: unexpected event beat kind=%0d slot=%0d time=%0d sum=%0d last=%0b",
						$time, got.kind, got.slot, got.etime, got.sum, got.last);
					fail_count++;
				end else begin
					want = event_q.pop_front();
					if (got !== want) begin
						$display("%0t: event mismatch expected kind=%0d slot=%0d time=%0d sum=%0d last=%0b",
							$time, want.kind, want.slot, want.etime, want.sum, want.last);
						$display("%0t:                actual   kind=%0d slot=%0d time=%0d sum=%0d last=%0b",
							$time, got.kind, got.slot, got.etime, got.sum, got.last);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_BLOCK_DURATION)
					block_len = cfg_data;
				else
					active_cnt = cfg_data[4:0];
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser)
					schedule_tick();
				else
					load_slot(s_axis_tdata);
			end
		end
	end

endmodule

// ===== tb/shortest_next_task_scheduler_unit_test.sv =====
// ----------------------------------------------------------------------------
// shortest_next_task_scheduler_unit_test
// drives load and tick beats plus register writes into the scheduler with
// random gaps and back-pressure, one long event stall, and reports the verdict
// from the checker's failure count
// ----------------------------------------------------------------------------
module shortest_next_task_scheduler_unit_test
	import snts_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 600000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [79:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [15:0] cfg_data;
	int          fail_count;
	int          pending;

	int send_idle_pct;
	int recv_idle_pct;
	int items_sent;
	int cycles;
	int hold_reqs;
	int hold_served;

	shortest_next_task_scheduler_unit dut (.*);

	shortest_next_task_scheduler_unit_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("[shortest_next_task_scheduler_unit] ERROR");
				$finish;
			end
		end
	end

	// event side ready, with one long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		hold_served = 0;
		forever begin
			@(negedge clk);
			if (hold_served != hold_reqs) begin
				m_axis_tready = 1'b0;
				repeat (400) @(negedge clk);
				hold_served++;
			end
			m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_beat(logic mode, logic [3:0] slot, logic [15:0] arr,
			logic [15:0] tot, logic [15:0] bur);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser = mode;
		s_axis_tdata = {4'b0, bur, tot, arr, slot};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic tick();
		send_beat(1'b1, 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	task automatic load(logic [3:0] slot, logic [15:0] arr, logic [15:0] tot,
			logic [15:0] bur);
		send_beat(1'b0, slot, arr, tot, bur);
	endtask

	task automatic settle();
		s_axis_tvalid = 1'b0;
		while (pending != 0 || hold_served != hold_reqs)
			@(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [15:0] pick_time(int hi);
		return ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(hi));
	endfunction

	initial begin
		int n;
		int tc;
		int phase;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_BLOCK_DURATION;
		cfg_data = '0;
		hold_reqs = 0;
		send_idle_pct = 15;
		recv_idle_pct = 72;
		items_sent = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// unloaded slot runs with zero times, then ticks after done are ignored
		tick();
		tick();
		tick();
		load(4'd0, 16'd0, 16'd2, 16'd1);
		repeat (6) tick();
		settle();
		// no active slots: done with a zero sum
		write_reg(REG_TASK_COUNT, 16'd0);
		tick();
		load(4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		tick();
		settle();
		// count above the slot total, zero block time, tied bursts
		write_reg(REG_TASK_COUNT, 16'd20);
		write_reg(REG_BLOCK_DURATION, 16'd0);
		load(4'd0, 16'd1, 16'd3, 16'd2);
		load(4'd1, 16'd0, 16'd3, 16'd2);
		load(4'd2, 16'd0, 16'd2, 16'd0);
		tick();
		tick();
		load(4'd2, 16'd2, 16'd1, 16'd1);
		repeat (5) tick();
		settle();

		phase = 0;
		while (items_sent < 310) begin
			if (items_sent > 220) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (items_sent > 110) begin
				send_idle_pct = 72;
				recv_idle_pct = 15;
			end
			case (phase % 5)
				0: write_reg(REG_BLOCK_DURATION, 16'hFFFF);
				1: write_reg(REG_BLOCK_DURATION, 16'd0);
				default: write_reg(REG_BLOCK_DURATION, 16'($urandom_range(4)));
			endcase
			case (phase % 6)
				0: tc = 16;
				1: tc = 1;
				2: tc = 31;
				default: tc = $urandom_range(2, 12);
			endcase
			write_reg(REG_TASK_COUNT, 16'(tc));
			n = (tc > 16) ? 16 : tc;
			if (phase == 3)
				hold_reqs++;
			for (int i = 0; i < n; i++)
				load(4'(i), pick_time(4), pick_time(6), pick_time(3));
			repeat (22) begin
				if ($urandom_range(9) == 0)
					load(4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
				else
					tick();
			end
			settle();
			phase++;
		end

		settle();
		if (fail_count == 0)
			$display("[shortest_next_task_scheduler_unit] OK");
		else
			$display("[shortest_next_task_scheduler_unit] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/snts_pkg.sv
hw/rtl/snts_evq.sv
hw/rtl/shortest_next_task_scheduler_unit.sv
tb/shortest_next_task_scheduler_unit_checker.sv
tb/shortest_next_task_scheduler_unit_test.sv
